>>> rtl/core/tmq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the typed message queue engine.
package tmq_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 80;
    localparam int CMD_W       = 3;
    localparam int SLOT_W      = 3;
    localparam int TYPE_W      = 32;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int CFG_W       = 5;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEND   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECV   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ERR   = 2'd2;

    localparam logic [CFG_W-1:0] MAX_MSG_RESET = 5'd16;

    // one stored message
    typedef struct packed {
        logic [TYPE_W-1:0] typ;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_search;
        logic chk;
        logic rd_shift;
        logic wr_shift;
        logic load_out;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic recv_go;
        logic empty;
        logic match;
        logic last;
        logic at_head;
        logic prev_at_head;
    } sts_t;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if ({1'b0, n} > 5'(b))
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/typed_message_queue_engine.sv
`timescale 1ns / 1ps
// Top level of the typed message queue engine.
//
//  channel  | dir | handshake                       | contents
//  ---------+-----+---------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready   | one command transaction
//  m_axis   | out | m_axis_tvalid / m_axis_tready   | one result transaction per command
//  cfg      | in  | cfg_valid / cfg_ready           | max_messages register write
//
// Steps: create, send, remove and count go from accept through execute to result.
// A receive adds a read and a check per entry examined by the search and a read
// and a write per entry moved by the compaction, both through the single read
// port of the message RAM.
// Reset: rst_n clears all queues to inactive and max_messages to 16; the message
// RAM is not cleared (entries are only read after a send wrote them).
// Stalls: one command at a time; the result sits in an output register, so the
// next command is accepted while an earlier result waits for m_axis_tready.
module typed_message_queue_engine #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_BYTES   = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // queue_slot[2:0], msg_type[34:3], length[38:35], payload[102:39], zero pad
    input  logic [tmq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[2:0]
    input  logic [tmq_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // copied_bytes[3:0], payload_out[67:4], message_count[72:68], zero pad
    output logic [tmq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [tmq_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmq_pkg::CFG_W-1:0]        cfg_data
);
    tmq_pkg::ctl_t ctl;
    tmq_pkg::sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    tmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tmq_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_BYTES  (MAX_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .in_tdata (s_axis_tdata),
        .in_tuser (s_axis_tuser),
        .ctl      (ctl),
        .sts      (sts),
        .out_tdata(m_axis_tdata),
        .out_tuser(m_axis_tuser)
    );
endmodule

>>> rtl/core/tmq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/tmq_dp.sv
`timescale 1ns / 1ps
// Datapath: per-queue pointers, message RAM, search and shift logic, result registers.
module tmq_dp #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_BYTES   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmq_pkg::CFG_W-1:0]           cfg_data,
    input  logic [tmq_pkg::IN_TDATA_W-1:0]      in_tdata,
    input  logic [tmq_pkg::CMD_W-1:0]           in_tuser,
    input  tmq_pkg::ctl_t                       ctl,
    output tmq_pkg::sts_t                       sts,
    output logic [tmq_pkg::OUT_TDATA_W-1:0]     out_tdata,
    output logic [tmq_pkg::STATUS_W-1:0]        out_tuser
);
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int EW      = $bits(tmq_pkg::entry_t);
    localparam int PAD_W   = tmq_pkg::OUT_TDATA_W - tmq_pkg::LEN_W - tmq_pkg::DATA_W
                             - tmq_pkg::COUNT_W;

    logic [tmq_pkg::CFG_W-1:0]    max_reg;
    logic [tmq_pkg::CMD_W-1:0]    cmd_reg;
    logic [tmq_pkg::SLOT_W-1:0]   slot_reg;
    logic [tmq_pkg::TYPE_W-1:0]   type_reg;
    logic [tmq_pkg::LEN_W-1:0]    len_reg;
    logic [tmq_pkg::DATA_W-1:0]   pay_reg;
    logic [NUM_QUEUES-1:0]        active_reg;
    logic [IW-1:0]                head_reg [NUM_QUEUES];
    logic [IW-1:0]                tail_reg [NUM_QUEUES];
    logic [CW-1:0]                cnt_reg  [NUM_QUEUES];
    logic [IW-1:0]                i_reg;
    logic [IW-1:0]                pos_reg;
    logic [tmq_pkg::STATUS_W-1:0] res_status_reg;
    logic [tmq_pkg::LEN_W-1:0]    res_copied_reg;
    logic [tmq_pkg::DATA_W-1:0]   res_pout_reg;
    logic [tmq_pkg::STATUS_W-1:0] out_status_reg;
    logic [tmq_pkg::LEN_W-1:0]    out_copied_reg;
    logic [tmq_pkg::DATA_W-1:0]   out_pout_reg;
    logic [tmq_pkg::COUNT_W-1:0]  out_count_reg;

    logic [QW+2:0]                slot_ext;
    logic [QW-1:0]                qi;
    logic                         slot_ok;
    logic                         act;
    logic [IW-1:0]                h;
    logic [IW-1:0]                t;
    logic [CW-1:0]                c;
    logic [IW-1:0]                h_inc;
    logic [IW-1:0]                t_inc;
    logic [IW:0]                  sum;
    logic [IW-1:0]                p;
    logic [IW-1:0]                prev;
    logic [AW-1:0]                base;
    logic                         full;
    logic                         send_ok;
    logic                         match;
    logic                         commit;
    logic [tmq_pkg::LEN_W-1:0]    copied;
    logic [tmq_pkg::STATUS_W-1:0] exec_status;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    tmq_pkg::entry_t              wr_entry;
    tmq_pkg::entry_t              rd_entry;
    logic [CW-1:0]                c_now;
    logic [CW+4:0]                c_ext;

    tmq_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_entry),
        .raddr(ram_raddr),
        .rdata(rd_entry)
    );

    always_comb
    begin
        slot_ext = (QW + 3)'(slot_reg);
        qi       = slot_ext[QW-1:0];
        slot_ok  = 32'(slot_reg) < 32'(NUM_QUEUES);
        act      = slot_ok && active_reg[qi];
        h        = head_reg[qi];
        t        = tail_reg[qi];
        c        = cnt_reg[qi];
        h_inc    = (h == IW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
        t_inc    = (t == IW'(QUEUE_DEPTH - 1)) ? '0 : t + 1'b1;
        sum      = (IW + 1)'(h) + (IW + 1)'(i_reg);
        p        = (sum >= (IW + 1)'(QUEUE_DEPTH)) ? IW'(sum - (IW + 1)'(QUEUE_DEPTH))
                                                   : IW'(sum);
        prev     = (pos_reg == '0) ? IW'(QUEUE_DEPTH - 1) : pos_reg - 1'b1;
        base     = AW'(qi) * AW'(QUEUE_DEPTH);
        full     = (32'(c) >= 32'(max_reg)) || (32'(c) >= 32'(QUEUE_DEPTH));
        send_ok  = act && (len_reg != '0) && (32'(len_reg) <= 32'(MAX_BYTES)) && !full;
        match    = (type_reg == '0) || (rd_entry.typ == type_reg);
        copied   = (len_reg < rd_entry.len) ? len_reg : rd_entry.len;
        commit   = (ctl.chk && match && (pos_reg == h)) || (ctl.wr_shift && (prev == h));

        case (cmd_reg)
            tmq_pkg::CMD_CREATE: exec_status = (slot_ok && !act) ? tmq_pkg::STS_OK
                                                                 : tmq_pkg::STS_ERR;
            tmq_pkg::CMD_SEND:   exec_status = send_ok ? tmq_pkg::STS_OK : tmq_pkg::STS_ERR;
            tmq_pkg::CMD_RECV:   exec_status = (act && (len_reg != '0)) ? tmq_pkg::STS_EMPTY
                                                                        : tmq_pkg::STS_ERR;
            tmq_pkg::CMD_REMOVE: exec_status = act ? tmq_pkg::STS_OK : tmq_pkg::STS_ERR;
            tmq_pkg::CMD_COUNT:  exec_status = act ? tmq_pkg::STS_OK : tmq_pkg::STS_ERR;
            default:             exec_status = tmq_pkg::STS_ERR;
        endcase

        ram_we        = (ctl.exec && (cmd_reg == tmq_pkg::CMD_SEND) && send_ok) || ctl.wr_shift;
        ram_waddr     = ctl.wr_shift ? base + AW'(pos_reg) : base + AW'(t);
        ram_raddr     = ctl.rd_shift ? base + AW'(prev) : base + AW'(p);
        wr_entry.typ  = ctl.wr_shift ? rd_entry.typ : type_reg;
        wr_entry.len  = ctl.wr_shift ? rd_entry.len : len_reg;
        wr_entry.data = ctl.wr_shift ? rd_entry.data
                                     : (pay_reg & tmq_pkg::byte_mask(len_reg));

        sts.recv_go      = act && (cmd_reg == tmq_pkg::CMD_RECV) && (len_reg != '0);
        sts.empty        = (c == '0);
        sts.match        = match;
        sts.last         = (CW'(i_reg) + CW'(1)) >= c;
        sts.at_head      = (pos_reg == h);
        sts.prev_at_head = (prev == h);

        c_now = act ? c : '0;
        c_ext = (CW + 5)'(c_now);
    end

    // config and per-queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= tmq_pkg::MAX_MSG_RESET;
            active_reg <= '0;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            if (ctl.exec && slot_ok)
            begin
                case (cmd_reg)
                    tmq_pkg::CMD_CREATE:
                    begin
                        if (!act)
                        begin
                            active_reg[qi] <= 1'b1;
                            head_reg[qi]   <= '0;
                            tail_reg[qi]   <= '0;
                            cnt_reg[qi]    <= '0;
                        end
                    end
                    tmq_pkg::CMD_SEND:
                    begin
                        if (send_ok)
                        begin
                            tail_reg[qi] <= t_inc;
                            cnt_reg[qi]  <= c + 1'b1;
                        end
                    end
                    tmq_pkg::CMD_REMOVE:
                    begin
                        if (act)
                        begin
                            active_reg[qi] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (commit)
            begin
                head_reg[qi] <= h_inc;
                cnt_reg[qi]  <= c - 1'b1;
            end
        end
    end

    // transaction and work registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= in_tuser;
            slot_reg <= in_tdata[2:0];
            type_reg <= in_tdata[34:3];
            len_reg  <= in_tdata[38:35];
            pay_reg  <= in_tdata[102:39];
        end
        if (ctl.exec)
        begin
            i_reg          <= '0;
            res_status_reg <= exec_status;
            res_copied_reg <= '0;
            res_pout_reg   <= '0;
        end
        if (ctl.rd_search)
        begin
            pos_reg <= p;
        end
        if (ctl.chk)
        begin
            if (match)
            begin
                res_status_reg <= tmq_pkg::STS_OK;
                res_copied_reg <= copied;
                res_pout_reg   <= rd_entry.data & tmq_pkg::byte_mask(copied);
            end
            else
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
        if (ctl.wr_shift)
        begin
            pos_reg <= prev;
        end
        if (ctl.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_copied_reg <= res_copied_reg;
            out_pout_reg   <= res_pout_reg;
            out_count_reg  <= c_ext[tmq_pkg::COUNT_W-1:0];
        end
    end

    assign out_tuser = out_status_reg;
    assign out_tdata = {{PAD_W{1'b0}}, out_count_reg, out_pout_reg, out_copied_reg};
endmodule

>>> rtl/core/tmq_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one command through execute, search, shift and result.
module tmq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  tmq_pkg::sts_t sts,
    output tmq_pkg::ctl_t ctl
);
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_SRCH_RD  = 7'b0000100,
        S_SRCH_CHK = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = (sts.recv_go && !sts.empty) ? S_SRCH_RD : S_DONE;
            end
            S_SRCH_RD:
            begin
                ctl.rd_search = 1'b1;
                state_next    = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                ctl.chk = 1'b1;
                if (sts.match)
                begin
                    state_next = sts.at_head ? S_DONE : S_SHIFT_RD;
                end
                else
                begin
                    state_next = sts.last ? S_DONE : S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ctl.rd_shift = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctl.wr_shift = 1'b1;
                state_next   = sts.prev_at_head ? S_DONE : S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = ctl.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

>>> verif/typed_message_queue_engine_checker.sv
`timescale 1ns / 1ps
// Checker for the typed message queue engine: predicts results and compares them.
module typed_message_queue_engine_checker
    import tmq_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_BYTES   = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [CMD_W-1:0]          s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic [STATUS_W-1:0]       m_axis_tuser,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_W-1:0]          cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    copied;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  count;
    } result_t;

    result_t result_q[$];

    logic [CFG_W-1:0]  limit_reg;
    logic              active[NUM_QUEUES];
    int                head[NUM_QUEUES];
    int                cnt[NUM_QUEUES];
    logic [TYPE_W-1:0] typ_mem[NUM_QUEUES][QUEUE_DEPTH];
    logic [LEN_W-1:0]  len_mem[NUM_QUEUES][QUEUE_DEPTH];
    logic [DATA_W-1:0] dat_mem[NUM_QUEUES][QUEUE_DEPTH];

    assign pending = result_q.size();

    function automatic logic [DATA_W-1:0] keep_bytes(input int n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < n)
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // runs one command against the shadow queues, returns its result
    function automatic result_t run_command(input logic [CMD_W-1:0] cmd,
                                            input logic [IN_TDATA_W-1:0] d);
        result_t r;
        int q, lim, pos, hp, prv, ml, c;
        logic [TYPE_W-1:0] typ;
        logic [LEN_W-1:0] len;
        logic [DATA_W-1:0] pay;
        logic found;
        q   = int'(d[2:0]);
        typ = d[34:3];
        len = d[38:35];
        pay = d[102:39];
        r = '0;
        r.status = STS_ERR;
        lim = (int'(limit_reg) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
        if (q < NUM_QUEUES)
        begin
            case (cmd)
                CMD_CREATE:
                    if (!active[q])
                    begin
                        active[q] = 1'b1;
                        head[q] = 0;
                        cnt[q] = 0;
                        r.status = STS_OK;
                    end
                CMD_SEND:
                    if (active[q] && len != 0 && len <= MAX_BYTES && cnt[q] < lim)
                    begin
                        pos = (head[q] + cnt[q]) % QUEUE_DEPTH;
                        typ_mem[q][pos] = typ;
                        len_mem[q][pos] = len;
                        dat_mem[q][pos] = pay & keep_bytes(int'(len));
                        cnt[q]++;
                        r.status = STS_OK;
                    end
                CMD_RECV:
                    if (active[q] && len != 0)
                    begin
                        r.status = STS_EMPTY;
                        found = 1'b0;
                        pos = 0;
                        hp = head[q];
                        for (int i = 0; i < cnt[q]; i++)
                        begin
                            if (!found && (typ == 0 ||
                                typ_mem[q][(hp + i) % QUEUE_DEPTH] == typ))
                            begin
                                found = 1'b1;
                                pos = (hp + i) % QUEUE_DEPTH;
                            end
                        end
                        if (found)
                        begin
                            ml = int'(len_mem[q][pos]);
                            c = (int'(len) < ml) ? int'(len) : ml;
                            r.copied = LEN_W'(c);
                            r.data = dat_mem[q][pos] & keep_bytes(c);
                            // close the gap by moving older entries toward the tail
                            while (pos != hp)
                            begin
                                prv = (pos == 0) ? QUEUE_DEPTH - 1 : pos - 1;
                                typ_mem[q][pos] = typ_mem[q][prv];
                                len_mem[q][pos] = len_mem[q][prv];
                                dat_mem[q][pos] = dat_mem[q][prv];
                                pos = prv;
                            end
                            head[q] = (hp + 1) % QUEUE_DEPTH;
                            cnt[q]--;
                            r.status = STS_OK;
                        end
                    end
                CMD_REMOVE:
                    if (active[q])
                    begin
                        active[q] = 1'b0;
                        r.status = STS_OK;
                    end
                CMD_COUNT:
                    if (active[q])
                    begin
                        r.status = STS_OK;
                    end
                default: ;
            endcase
            r.count = active[q] ? COUNT_W'(cnt[q]) : '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got;
        if (!rst_n)
        begin
            limit_reg <= MAX_MSG_RESET;
            fail_count <= 0;
            result_q.delete();
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                active[i] = 1'b0;
                head[i] = 0;
                cnt[i] = 0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(run_command(s_axis_tuser, s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.copied = m_axis_tdata[3:0];
                got.data   = m_axis_tdata[67:4];
                got.count  = m_axis_tdata[72:68];
                if (result_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (got != exp_r)
                    begin
                        fail_count <= fail_count + 1;
                        if (got.status != exp_r.status)
                            $error("status exp %0d got %0d", exp_r.status, got.status);
                        if (got.copied != exp_r.copied)
                            $error("copied_bytes exp %0d got %0d", exp_r.copied, got.copied);
                        if (got.data != exp_r.data)
                            $error("payload_out exp %h got %h", exp_r.data, got.data);
                        if (got.count != exp_r.count)
                            $error("message_count exp %0d got %0d", exp_r.count, got.count);
                    end
                end
            end
        end
    end

endmodule

>>> verif/typed_message_queue_engine_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the typed message queue engine.
module typed_message_queue_engine_tb;
    import tmq_pkg::*;

    localparam int LONG_RUN = 1350;
    localparam int CYCLE_LIMIT = 900000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    int                     fail_count;
    int                     pending;
    int                     cycles = 0;
    logic                   hold_rx = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    typed_message_queue_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typed_message_queue_engine_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random ready, plus a long forced hold-off when asked
    always @(posedge clk)
    begin
        int g;
        if (rst_n)
        begin
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else
            begin
                g = pick_gap();
                m_axis_tready <= (g == 0);
            end
        end
    end

    // valid stays up between back-to-back transactions; it drops only for a gap
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [2:0] slot,
                            input logic [31:0] typ, input logic [3:0] len,
                            input logic [63:0] pay, input logic no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, pay, len, typ, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small type set so filtered receives often hit; zero means any type
    function automatic logic [31:0] rand_type();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 32'h0;
        if (r < 9)
            return 32'(r);
        return $urandom();
    endfunction

    task automatic random_phase(input int n, input int err_pct);
        logic [CMD_W-1:0] cmd;
        logic [3:0] len;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                cmd = CMD_CREATE;
            else if (r < 48)
                cmd = CMD_SEND;
            else if (r < 85)
                cmd = CMD_RECV;
            else if (r < 90)
                cmd = CMD_REMOVE;
            else if (r < 97)
                cmd = CMD_COUNT;
            else
                cmd = CMD_W'($urandom_range(5, 7));
            if ($urandom_range(0, 99) < err_pct)
                len = 4'($urandom_range(0, 15));
            else
                len = 4'($urandom_range(1, 8));
            send_cmd(cmd, 3'($urandom_range(0, 7)), rand_type(), len, rand64(), 1'b0);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: error paths on inactive queues, unknown command, then slot 7 create/send/receive
        send_cmd(CMD_SEND, 3'd0, 32'h1, 4'd1, 64'hFF, 1'b0);
        send_cmd(CMD_RECV, 3'd0, 32'h0, 4'd8, '0, 1'b0);
        send_cmd(CMD_REMOVE, 3'd0, '0, '0, '0, 1'b0);
        send_cmd(CMD_COUNT, 3'd0, '0, '0, '0, 1'b0);
        send_cmd(3'd7, 3'd7, '1, '1, '1, 1'b0);
        send_cmd(CMD_CREATE, 3'd7, '0, '0, '0, 1'b0);
        send_cmd(CMD_CREATE, 3'd7, '0, '0, '0, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'h0, 4'd4, '0, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'hFFFFFFFF, 4'd0, '1, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'hFFFFFFFF, 4'd9, '1, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'hFFFFFFFF, 4'd15, '1, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'hFFFFFFFF, 4'd8, '1, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'h5, 4'd3, 64'hA5A5_5A5A_DEAD_BEEF, 1'b0);
        send_cmd(CMD_SEND, 3'd7, 32'h6, 4'd1, '1, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'h0, 4'd0, '0, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'h9, 4'd8, '0, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'h6, 4'd8, '0, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'h0, 4'd2, '0, 1'b0);
        send_cmd(CMD_RECV, 3'd7, 32'hFFFFFFFF, 4'd15, '0, 1'b0);
        send_cmd(CMD_COUNT, 3'd7, '0, '0, '0, 1'b0);
        send_cmd(CMD_REMOVE, 3'd7, '0, '0, '0, 1'b0);
        send_cmd(CMD_COUNT, 3'd7, '0, '0, '0, 1'b0);

        // limit of one: second send finds the queue full
        write_limit(5'd1);
        send_cmd(CMD_CREATE, 3'd1, '0, '0, '0, 1'b0);
        send_cmd(CMD_SEND, 3'd1, 32'h2, 4'd8, rand64(), 1'b0);
        send_cmd(CMD_SEND, 3'd1, 32'h2, 4'd8, rand64(), 1'b0);
        random_phase(150, 10);

        // hold the result side while commands keep coming
        drain();
        hold_rx = 1'b1;
        fork
            random_phase(20, 5);
            begin
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
        join

        // limit above depth acts as full depth
        write_limit(5'd31);
        for (int s = 0; s < 8; s++)
            send_cmd(CMD_CREATE, 3'(s), '0, '0, '0, 1'b1);
        for (int k = 0; k < 18; k++)
            send_cmd(CMD_SEND, 3'd3, rand_type(), 4'($urandom_range(1, 8)), rand64(), 1'b1);
        random_phase(400, 10);

        write_limit(5'd0);
        random_phase(60, 20);
        write_limit(5'd5);
        random_phase(300, 10);
        write_limit(5'd16);
        random_phase(380, 10);

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> typed_message_queue_engine.f
rtl/core/tmq_pkg.sv
rtl/core/tmq_ram.sv
rtl/core/tmq_dp.sv
rtl/core/tmq_ctrl.sv
rtl/core/typed_message_queue_engine.sv
verif/typed_message_queue_engine_checker.sv
verif/typed_message_queue_engine_tb.sv
